// ===== rtl/nca_pkg.sv =====
// ----------------------------------------------------------------------------
// nca_pkg
// Shared types and constants for the nearest centroid assignment block.
// ----------------------------------------------------------------------------
package nca_pkg;

	localparam int COORD_W   = 16;
	localparam int IN_COORDS = 4;
	localparam int SQ_W      = 32;
	localparam int SUM_W     = 35;
	localparam int DIST_W    = 34;
	localparam int POS_W     = 16;
	localparam int CL_W      = 3;
	localparam int SLOT_W    = 3;
	localparam int KIND_W    = 2;
	localparam int CIU_W     = 4;

	localparam int MAX_CLUSTERS_DEF = 8;
	localparam int DIMENSIONS_DEF   = 4;
	localparam int MAX_MEMBERS_DEF  = 65536;

	localparam logic [CIU_W-1:0]  CIU_RESET = 4'd8;
	localparam logic [DIST_W-1:0] DIST_MAX  = '1;
	localparam logic [POS_W-1:0]  POS_MAX   = '1;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POINT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// tag that travels with one centroid compare
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} nca_tag_t;

	typedef struct packed {
		logic [CL_W-1:0]   nearest;
		logic [DIST_W-1:0] sqd;
		logic [POS_W-1:0]  pos;
		logic              worse;
	} nca_res_t;

endpackage

// ===== rtl/nca_lane.sv =====
// ----------------------------------------------------------------------------
// nca_lane
// One dimension lane: centroid coordinate store and squared difference.
// ----------------------------------------------------------------------------
module nca_lane import nca_pkg::*; #(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	localparam int CI_W = $clog2(MAX_CLUSTERS)
) (
	input  logic                      clk,
	input  logic signed [COORD_W-1:0] coord,
	input  logic                      wr_en,
	input  logic [CI_W-1:0]           wr_addr,
	input  logic                      pt_ld,
	input  logic [CI_W-1:0]           rd_addr,
	output logic [SQ_W-1:0]           sq
);

	logic signed [COORD_W-1:0] mem [MAX_CLUSTERS];
	logic signed [COORD_W-1:0] rd_s1;
	logic signed [COORD_W-1:0] pt_q;
	logic signed [COORD_W:0]   diff;
	logic signed [2*COORD_W+1:0] prod;
	logic [SQ_W-1:0]           sq_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= coord;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pt_ld) begin
			pt_q <= coord;
		end
	end

	assign diff = {pt_q[COORD_W-1], pt_q} - {rd_s1[COORD_W-1], rd_s1};
	assign prod = diff * diff;

	always_ff @(posedge clk) begin
		sq_s2 <= prod[SQ_W-1:0];
	end

	assign sq = sq_s2;

endmodule

// ===== rtl/nca_merge.sv =====
// ----------------------------------------------------------------------------
// nca_merge
// Sums the lane squares, saturates, and keeps the running nearest centroid.
// ----------------------------------------------------------------------------
module nca_merge import nca_pkg::*; #(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int DIMENSIONS   = DIMENSIONS_DEF,
	localparam int CI_W = $clog2(MAX_CLUSTERS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nca_tag_t          iss,
	input  logic [CI_W-1:0]   iss_idx,
	input  logic [SQ_W-1:0]   sq [DIMENSIONS],
	output logic              done,
	output logic [CI_W-1:0]   best_idx,
	output logic [DIST_W-1:0] best_dist
);

	nca_tag_t          tag_s1, tag_s2, tag_s3;
	logic [CI_W-1:0]   idx_s1, idx_s2, idx_s3;
	logic [DIST_W-1:0] sum_s3;
	logic [SUM_W-1:0]  total;
	logic [CI_W-1:0]   best_idx_q;
	logic [DIST_W-1:0] best_dist_q;
	logic              done_q;

	always_comb begin
		total = '0;
		for (int d = 0; d < DIMENSIONS; d++) begin
			total = total + SUM_W'(sq[d]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= iss;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			done_q <= tag_s3.vld && tag_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_idx;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		sum_s3 <= (total > SUM_W'(DIST_MAX)) ? DIST_MAX : total[DIST_W-1:0];
		// strict less-than: lowest index wins a tie
		if (tag_s3.vld && (tag_s3.first || sum_s3 < best_dist_q)) begin
			best_dist_q <= sum_s3;
			best_idx_q  <= idx_s3;
		end
	end

	assign done      = done_q;
	assign best_idx  = best_idx_q;
	assign best_dist = best_dist_q;

endmodule

// ===== rtl/nca_stats.sv =====
// ----------------------------------------------------------------------------
// nca_stats
// Per-cluster member count and worst distance for the current pass.
// ----------------------------------------------------------------------------
module nca_stats import nca_pkg::*; #(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int MAX_MEMBERS  = MAX_MEMBERS_DEF,
	localparam int CI_W  = $clog2(MAX_CLUSTERS),
	localparam int CNT_W = $clog2(MAX_MEMBERS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              clear,
	input  logic [CI_W-1:0]   idx,
	input  logic [DIST_W-1:0] sqd,
	output nca_res_t          res
);

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [DIST_W-1:0] worst;
	} row_t;

	row_t              mem [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0] vld_q;
	row_t              row_s1;
	logic              rv_s1;
	logic              go_s1;
	logic [CI_W-1:0]   idx_s1;
	logic [DIST_W-1:0] dist_s1;

	logic [CNT_W-1:0]  cnt;
	logic [DIST_W-1:0] worst;
	logic              full;
	logic [CNT_W-1:0]  pos;
	logic              worse;
	row_t              row_new;

	always_comb begin
		cnt   = rv_s1 ? row_s1.cnt : '0;
		worst = rv_s1 ? row_s1.worst : '0;
		full  = cnt >= CNT_W'(MAX_MEMBERS);
		pos   = full ? CNT_W'(MAX_MEMBERS - 1) : cnt;
		worse = dist_s1 > worst;
		row_new.cnt   = full ? cnt : cnt + CNT_W'(1);
		row_new.worst = worse ? dist_s1 : worst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= start;
			if (clear) begin
				vld_q <= '0;
			end else if (go_s1) begin
				vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			mem[idx_s1] <= row_new;
		end
		row_s1  <= mem[idx];
		rv_s1   <= vld_q[idx];
		idx_s1  <= idx;
		dist_s1 <= sqd;
	end

	assign res.nearest = CL_W'(idx_s1);
	assign res.sqd     = dist_s1;
	assign res.pos     = (32'(pos) > 32'(POS_MAX)) ? POS_MAX : POS_W'(pos);
	assign res.worse   = worse;

endmodule

// ===== rtl/nearest_centroid_assign.sv =====
// A point's result passes the lane registers, the merge pipeline, a hold state that waits
// while the output is stalled and the statistics update; n = clusters in use.
// A point occupies the block until its result is registered: the shared lane pass scans one
// centroid per cycle over n centroids; load and clear items are taken one per cycle while idle.
// Reset (arst_n low, asynchronous): clusters in use returns to 8, pass statistics clear,
// the output register empties. Centroid slots hold no value until loaded.
// ----------------------------------------------------------------------------
// nearest_centroid_assign
// k-means assignment step: one lane per dimension, centroids scanned in turn.
// ----------------------------------------------------------------------------
module nearest_centroid_assign import nca_pkg::*; #(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int DIMENSIONS   = DIMENSIONS_DEF,
	parameter int MAX_MEMBERS  = MAX_MEMBERS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CIU_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [KIND_W-1:0]         kind,
	input  logic [SLOT_W-1:0]         centroid_index,
	input  logic signed [COORD_W-1:0] coord_0,
	input  logic signed [COORD_W-1:0] coord_1,
	input  logic signed [COORD_W-1:0] coord_2,
	input  logic signed [COORD_W-1:0] coord_3,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [CL_W-1:0]           nearest_cluster,
	output logic [DIST_W-1:0]         squared_distance,
	output logic [POS_W-1:0]          member_position,
	output logic                      new_worst
);

	localparam int CI_W = $clog2(MAX_CLUSTERS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_HOLD = 3'd3;
	localparam logic [2:0] S_STAT = 3'd4;

	logic [2:0]        state_q;
	logic [CIU_W-1:0]  ciu_q;
	logic [CI_W-1:0]   last_q;
	logic [CI_W-1:0]   last_nxt;
	logic [CI_W-1:0]   iss_q;
	logic              acc;
	logic              out_free;
	logic              wr_en;
	logic              stat_start;
	nca_tag_t          iss;

	logic signed [COORD_W-1:0] coord_in [IN_COORDS];
	logic signed [COORD_W-1:0] lane_coord [DIMENSIONS];
	logic [SQ_W-1:0]   sq [DIMENSIONS];

	logic              done;
	logic [CI_W-1:0]   best_idx;
	logic [DIST_W-1:0] best_dist;
	nca_res_t          res;

	logic              out_valid_q;
	nca_res_t          out_q;

	assign coord_in[0] = coord_0;
	assign coord_in[1] = coord_1;
	assign coord_in[2] = coord_2;
	assign coord_in[3] = coord_3;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign acc       = in_valid && !in_stall;
	assign wr_en     = acc && (kind == KIND_LOAD) && (int'(centroid_index) < MAX_CLUSTERS);
	assign out_free  = !out_valid_q || !out_stall;
	assign stat_start = (state_q == S_HOLD) && out_free;

	// last centroid index compared: 0 acts as 1, too many acts as all
	always_comb begin
		if (ciu_q == '0) begin
			last_nxt = '0;
		end else if (int'(ciu_q) > MAX_CLUSTERS) begin
			last_nxt = CI_W'(MAX_CLUSTERS - 1);
		end else begin
			last_nxt = CI_W'(ciu_q - CIU_W'(1));
		end
	end

	assign iss.vld   = (state_q == S_SCAN);
	assign iss.first = (iss_q == '0);
	assign iss.last  = (iss_q == last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciu_q <= CIU_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ciu_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iss_q   <= '0;
			last_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc && kind == KIND_POINT) begin
						state_q <= S_SCAN;
						iss_q   <= '0;
						last_q  <= last_nxt;
					end
				end
				S_SCAN: begin
					if (iss_q == last_q) begin
						state_q <= S_WAIT;
					end else begin
						iss_q <= iss_q + CI_W'(1);
					end
				end
				S_WAIT: begin
					if (done) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_STAT;
					end
				end
				S_STAT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	for (genvar d = 0; d < DIMENSIONS; d++) begin : g_lane
		if (d < IN_COORDS) begin : g_in
			assign lane_coord[d] = coord_in[d];
		end else begin : g_zero
			assign lane_coord[d] = '0;
		end

		nca_lane #(
			.MAX_CLUSTERS(MAX_CLUSTERS)
		) u_lane (
			.clk     (clk),
			.coord   (lane_coord[d]),
			.wr_en   (wr_en),
			.wr_addr (CI_W'(centroid_index)),
			.pt_ld   (acc),
			.rd_addr (iss_q),
			.sq      (sq[d])
		);
	end

	nca_merge #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.DIMENSIONS  (DIMENSIONS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.iss       (iss),
		.iss_idx   (iss_q),
		.sq        (sq),
		.done      (done),
		.best_idx  (best_idx),
		.best_dist (best_dist)
	);

	nca_stats #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.MAX_MEMBERS (MAX_MEMBERS)
	) u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (stat_start),
		.clear  (acc && kind == KIND_CLEAR),
		.idx    (best_idx),
		.sqd    (best_dist),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_STAT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_STAT) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign nearest_cluster  = out_q.nearest;
	assign squared_distance = out_q.sqd;
	assign member_position  = out_q.pos;
	assign new_worst        = out_q.worse;

endmodule

// ===== rtl/nca_checker.sv =====
// ----------------------------------------------------------------------------
// nca_checker
// Port-level checks for nearest_centroid_assign, bound to the top level.
// ----------------------------------------------------------------------------
module nca_checker import nca_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic [KIND_W-1:0]         kind,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [CL_W-1:0]           nearest_cluster,
	input logic [DIST_W-1:0]         squared_distance,
	input logic [POS_W-1:0]          member_position,
	input logic                      new_worst
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(nearest_cluster) &&
		$stable(squared_distance) && $stable(member_position) && $stable(new_worst))
		else $error("stalled result beat changed");

	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == KIND_POINT |=> in_stall)
		else $error("point beat did not occupy the block");

	a_other_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind != KIND_POINT |=> !in_stall)
		else $error("load or clear beat stalled the input");

	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a point in flight");

	a_worst_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_worst |-> squared_distance != '0)
		else $error("zero distance flagged as new worst");

endmodule

bind nearest_centroid_assign nca_checker u_nca_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.kind             (kind),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.nearest_cluster  (nearest_cluster),
	.squared_distance (squared_distance),
	.member_position  (member_position),
	.new_worst        (new_worst)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_centroid_assign. Loads, clears and points
// go in through a valid/stall channel; each accepted beat updates a shadow
// k-means assignment model that queues the expected nearest cluster,
// distance, member position and new-worst flag. Every output beat is checked
// against the oldest entry. Phases rewrite clusters in use, including the
// out-of-range values, with random idling, stall bursts and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb;
	import nca_pkg::*;

	localparam int NCL = MAX_CLUSTERS_DEF;
	localparam logic [KIND_W-1:0] KIND_SKIP = 2'd3;
	localparam int SETTLE = 40;

	typedef logic [IN_COORDS-1:0][COORD_W-1:0] coords_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		coords_t           crd;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CIU_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [SLOT_W-1:0] centroid_index = '0;
	logic signed [COORD_W-1:0] coord_0 = '0;
	logic signed [COORD_W-1:0] coord_1 = '0;
	logic signed [COORD_W-1:0] coord_2 = '0;
	logic signed [COORD_W-1:0] coord_3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CL_W-1:0] nearest_cluster;
	logic [DIST_W-1:0] squared_distance;
	logic [POS_W-1:0] member_position;
	logic new_worst;

	nearest_centroid_assign dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.centroid_index   (centroid_index),
		.coord_0          (coord_0),
		.coord_1          (coord_1),
		.coord_2          (coord_2),
		.coord_3          (coord_3),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.nearest_cluster  (nearest_cluster),
		.squared_distance (squared_distance),
		.member_position  (member_position),
		.new_worst        (new_worst)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow assignment model
	coords_t          cent_mem [NCL];
	int unsigned      members [NCL];
	longint unsigned  worst_d [NCL];
	logic [CIU_W-1:0] ciu_cfg = CIU_RESET;
	nca_res_t         expected_assign [$];

	function automatic longint unsigned sq_distance(beat_t b, int c);
		longint unsigned acc;
		longint df;
		acc = 0;
		for (int d = 0; d < IN_COORDS; d++) begin
			df = longint'($signed(b.crd[d])) - longint'($signed(cent_mem[c][d]));
			acc += longint'(df * df);
			if (acc > 64'(DIST_MAX))
				acc = 64'(DIST_MAX);
		end
		return acc;
	endfunction

	function automatic void absorb(beat_t b);
		int unsigned n;
		int unsigned best;
		int unsigned p;
		longint unsigned bd;
		longint unsigned dd;
		nca_res_t r;
		case (b.kind)
		KIND_LOAD: begin
			cent_mem[b.slot] = b.crd;
		end
		KIND_CLEAR: begin
			for (int c = 0; c < NCL; c++) begin
				members[c] = 0;
				worst_d[c] = 0;
			end
		end
		KIND_POINT: begin
			n = 32'(ciu_cfg);
			if (n < 1)
				n = 1;
			if (n > NCL)
				n = NCL;
			best = 0;
			bd = sq_distance(b, 0);
			for (int c = 1; c < n; c++) begin
				dd = sq_distance(b, c);
				if (dd < bd) begin
					bd = dd;
					best = c;
				end
			end
			p = members[best];
			if (p >= MAX_MEMBERS_DEF)
				p = MAX_MEMBERS_DEF - 1;
			else
				members[best] = members[best] + 1;
			r.nearest = best[CL_W-1:0];
			r.sqd = bd[DIST_W-1:0];
			r.pos = (p > POS_MAX) ? POS_MAX : p[POS_W-1:0];
			r.worse = bd > worst_d[best];
			if (r.worse)
				worst_d[best] = bd;
			expected_assign.insert(expected_assign.size(), r);
		end
		default: ;
		endcase
	endfunction

	// input driver
	beat_t pend [$];
	beat_t cur;
	int gap_left = 0;
	int n_in = 0;
	int idle_pct = 0;
	bit quiet = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb(cur);
				n_in <= n_in + 1;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pend.size() != 0) begin
					cur = pend.pop_front();
					kind <= cur.kind;
					centroid_index <= cur.slot;
					coord_0 <= cur.crd[0];
					coord_1 <= cur.crd[1];
					coord_2 <= cur.crd[2];
					coord_3 <= cur.crd[3];
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 99) < idle_pct)
						gap_left = $urandom_range(1, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long output hold-off so the block backs up into its input
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_in >= 150) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end
	end

	// output monitor
	int stall_left = 0;
	int n_err = 0;

	function automatic void cmp_field(string nm, logic [63:0] e, logic [63:0] g);
		if (e !== g) begin
			n_err++;
			$display("%0t: %s expected %0d, got %0d", $time, nm, e, g);
		end
	endfunction

	function automatic void check_result();
		nca_res_t e;
		if (expected_assign.size() == 0) begin
			n_err++;
			$display("%0t: unexpected beat, cluster %0d distance %0d", $time,
				nearest_cluster, squared_distance);
		end else begin
			e = expected_assign.pop_front();
			cmp_field("nearest_cluster", 64'(e.nearest), 64'(nearest_cluster));
			cmp_field("squared_distance", 64'(e.sqd), 64'(squared_distance));
			cmp_field("member_position", 64'(e.pos), 64'(member_position));
			cmp_field("new_worst", 64'(e.worse), 64'(new_worst));
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (stall_left > 0)
				stall_left--;
			else if (!quiet && $urandom_range(0, 99) < idle_pct)
				stall_left = $urandom_range(1, 10);
			out_stall <= (stall_left > 0) || (hold_left > 0);
		end
	end

	// stimulus
	coords_t gen_cent [NCL];

	function automatic void add_item(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
			logic [COORD_W-1:0] a0, logic [COORD_W-1:0] a1,
			logic [COORD_W-1:0] a2, logic [COORD_W-1:0] a3);
		beat_t t;
		t.kind = k;
		t.slot = s;
		t.crd = {a3, a2, a1, a0};
		if (k == KIND_LOAD)
			gen_cent[s] = t.crd;
		pend.insert(pend.size(), t);
	endfunction

	task automatic fill_random(int cnt);
		int r;
		int m;
		int c;
		int span;
		coords_t v;
		span = (ciu_cfg == '0) ? 1 : (int'(ciu_cfg) > NCL) ? NCL : int'(ciu_cfg);
		repeat (cnt) begin
			r = $urandom_range(0, 99);
			m = $urandom_range(0, 9);
			c = $urandom_range(0, span - 1);
			for (int d = 0; d < IN_COORDS; d++) begin
				if (m < 2)
					v[d] = 16'($urandom);
				else if (m < 4)
					v[d] = gen_cent[c][d];
				else
					v[d] = gen_cent[c][d] + 16'($urandom_range(0, 1023)) - 16'd512;
			end
			if (r < 5)
				add_item(KIND_LOAD, 3'($urandom), v[0], v[1], v[2], v[3]);
			else if (r < 8)
				add_item(KIND_CLEAR, 3'($urandom), v[0], v[1], v[2], v[3]);
			else if (r < 10)
				add_item(KIND_SKIP, 3'($urandom), v[0], v[1], v[2], v[3]);
			else
				add_item(KIND_POINT, 3'($urandom), v[0], v[1], v[2], v[3]);
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pend.size() != 0 || in_valid || expected_assign.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_ciu(logic [CIU_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		ciu_cfg = v;
	endtask

	task automatic run_phase(int pct, int cnt);
		@(negedge clk);
		idle_pct = pct;
		fill_random(cnt);
		drain();
	endtask

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		set_ciu(4'd8);
		@(negedge clk);
		add_item(KIND_LOAD, 3'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_item(KIND_LOAD, 3'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_item(KIND_LOAD, 3'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_item(KIND_LOAD, 3'd3, 16'h1000, 16'hF000, 16'h2000, 16'hE000);
		add_item(KIND_LOAD, 3'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		for (int s = 5; s < NCL; s++)
			add_item(KIND_LOAD, 3'(s), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
		add_item(KIND_CLEAR, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0);
		// zero distance never sets the worst flag
		add_item(KIND_POINT, 3'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_item(KIND_POINT, 3'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		// tie between slots 2 and 4, lower index wins
		add_item(KIND_POINT, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_item(KIND_POINT, 3'd0, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
		add_item(KIND_POINT, 3'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		add_item(KIND_POINT, 3'd0, 16'h0000, 16'h0002, 16'h0000, 16'h0000);
		add_item(KIND_SKIP, 3'd5, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
		add_item(KIND_POINT, 3'd0, 16'h1000, 16'hF000, 16'h2000, 16'hE010);
		add_item(KIND_CLEAR, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_item(KIND_POINT, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0003);
		add_item(KIND_LOAD, 3'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
		add_item(KIND_POINT, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0003);
		drain();

		// single centroid, largest possible distance first
		set_ciu(4'd1);
		@(negedge clk);
		add_item(KIND_POINT, 3'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		run_phase(25, 60);

		set_ciu(4'd15);
		run_phase(25, 70);
		set_ciu(4'd0);
		run_phase(0, 50);
		set_ciu(4'd3);
		run_phase(25, 70);
		set_ciu(4'($urandom_range(2, 7)));
		run_phase(25, 70);
		set_ciu(4'd8);
		run_phase(25, 70);

		set_ciu(4'd5);
		@(negedge clk);
		quiet = 1'b1;
		run_phase(0, 50);

		if (n_err == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
